>>> sv/sfl_pkg.sv
// ----------------------------------------------------------------------------
// sfl_pkg
// Shared widths, item codes and controller states for the symbol floor lookup.
// ----------------------------------------------------------------------------
package sfl_pkg;

    localparam int DEPTH_DEFAULT = 1024;

    localparam int ADDR_W  = 64;
    localparam int NAME_W  = 32;
    localparam int COUNT_W = 11;
    localparam int ENTRY_W = 10;

    localparam logic ACTION_LOAD  = 1'b0;
    localparam logic ACTION_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } sfl_state_t;

endpackage

>>> sv/sfl_table.sv
// ----------------------------------------------------------------------------
// sfl_table
// Symbol table memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sfl_table #(
    parameter int TABLE_DEPTH = sfl_pkg::DEPTH_DEFAULT,
    parameter int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [IDX_W-1:0]          wr_idx,
    input  logic [sfl_pkg::ADDR_W-1:0] wr_addr,
    input  logic [sfl_pkg::NAME_W-1:0] wr_name,
    input  logic                      rd_en,
    input  logic [IDX_W-1:0]          rd_idx,
    output logic [sfl_pkg::ADDR_W-1:0] rd_addr,
    output logic [sfl_pkg::NAME_W-1:0] rd_name
);
    import sfl_pkg::*;

    localparam int WORD_W = ADDR_W + NAME_W;

    logic [WORD_W-1:0] mem [TABLE_DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= {wr_addr, wr_name};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    assign rd_addr = rd_data_reg[WORD_W-1:NAME_W];
    assign rd_name = rd_data_reg[NAME_W-1:0];

endmodule

>>> sv/sfl_scan.sv
// ----------------------------------------------------------------------------
// sfl_scan
// Query sequencer: walks the table one entry a cycle, keeps the running
// floor match and holds the result in an output register.
// ----------------------------------------------------------------------------
module sfl_scan #(
    parameter int TABLE_DEPTH = sfl_pkg::DEPTH_DEFAULT,
    parameter int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        action,
    input  logic [sfl_pkg::ADDR_W-1:0]  address,
    input  logic [sfl_pkg::COUNT_W-1:0] symbol_count,
    output logic                        rd_en,
    output logic [IDX_W-1:0]            rd_idx,
    input  logic [sfl_pkg::ADDR_W-1:0]  rd_addr,
    input  logic [sfl_pkg::NAME_W-1:0]  rd_name,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        found,
    output logic [sfl_pkg::ADDR_W-1:0]  symbol_address,
    output logic [sfl_pkg::NAME_W-1:0]  symbol_name_offset
);
    import sfl_pkg::*;

    localparam int CNT_W = IDX_W + 1;

    sfl_state_t        state_reg;
    sfl_state_t        state_next;

    logic [CNT_W-1:0]  issue_idx_reg;
    logic [CNT_W-1:0]  limit_reg;
    logic [CNT_W-1:0]  limit_sat;
    logic              pend_reg;
    logic [ADDR_W-1:0] query_addr_reg;
    logic [ADDR_W-1:0] best_addr_reg;
    logic [NAME_W-1:0] best_name_reg;
    logic              hit_reg;

    logic              out_valid_reg;
    logic              found_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    logic [NAME_W-1:0] out_name_reg;

    logic              start;
    logic              issue;
    logic              better;
    logic              load_out;

    // count above the table depth scans the whole table
    assign limit_sat = (32'(symbol_count) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                               : CNT_W'(symbol_count);

    assign start  = in_valid && (state_reg == ST_IDLE) && (action == ACTION_QUERY);
    assign issue  = (state_reg == ST_SCAN) && (issue_idx_reg < limit_reg);
    // later entry wins on equal start address
    assign better = (query_addr_reg >= rd_addr) && (rd_addr >= best_addr_reg);
    assign rd_idx = issue_idx_reg[IDX_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!issue && !pend_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        rd_en    = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_SCAN:
            begin
                rd_en = issue;
            end
            ST_DONE:
            begin
                load_out = !out_valid_reg || !out_stall;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= issue;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            issue_idx_reg  <= '0;
            limit_reg      <= limit_sat;
            query_addr_reg <= address;
            best_addr_reg  <= '0;
            best_name_reg  <= '0;
            hit_reg        <= 1'b0;
        end
        else
        begin
            if (issue)
            begin
                issue_idx_reg <= issue_idx_reg + 1'b1;
            end
            if (pend_reg && better)
            begin
                best_addr_reg <= rd_addr;
                best_name_reg <= rd_name;
                hit_reg       <= 1'b1;
            end
        end
        if (load_out)
        begin
            found_reg    <= hit_reg;
            out_addr_reg <= best_addr_reg;
            out_name_reg <= best_name_reg;
        end
    end

    assign out_valid          = out_valid_reg;
    assign found              = found_reg;
    assign symbol_address     = out_addr_reg;
    assign symbol_name_offset = out_name_reg;

endmodule

>>> sv/symbol_floor_lookup_top.sv
// ----------------------------------------------------------------------------
// symbol_floor_lookup_top
// Symbol table with floor lookup: greatest start address not above a query.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one item per handshake. A load item
// (action 0) writes address and name_offset into slot entry_index; slots
// at or above TABLE_DEPTH are ignored. A query item (action 1) scans slots
// 0 .. n-1, with n = min(symbol_count, TABLE_DEPTH), one slot a cycle
// through the single table read port, and yields one result item.
// Output channel (out_valid / out_stall): found, symbol_address and
// symbol_name_offset, held in an output register.
// The next item after a query is taken the cycle after its result is
// registered. A stalled result holds in the output register; a following
// item may be accepted and scanned meanwhile, and its result waits until
// the register frees. symbol_count is written by cfg_wr_en / cfg_wr_data;
// the user must write it only while idle, the block does not enforce this.
// Reset clears control state and symbol_count; table contents are undefined
// until loaded.
// ----------------------------------------------------------------------------
module symbol_floor_lookup_top #(
    parameter int TABLE_DEPTH = sfl_pkg::DEPTH_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [sfl_pkg::COUNT_W-1:0] cfg_wr_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        action,
    input  logic [sfl_pkg::ENTRY_W-1:0] entry_index,
    input  logic [sfl_pkg::ADDR_W-1:0]  address,
    input  logic [sfl_pkg::NAME_W-1:0]  name_offset,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        found,
    output logic [sfl_pkg::ADDR_W-1:0]  symbol_address,
    output logic [sfl_pkg::NAME_W-1:0]  symbol_name_offset
);
    import sfl_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [COUNT_W-1:0] symbol_count_reg;
    logic               wr_en;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_idx;
    logic [ADDR_W-1:0]  rd_addr;
    logic [NAME_W-1:0]  rd_name;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            symbol_count_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            symbol_count_reg <= cfg_wr_data;
        end
    end

    assign wr_en = in_valid && !in_stall && (action == ACTION_LOAD)
                   && (32'(entry_index) < 32'(TABLE_DEPTH));

    sfl_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_idx  (IDX_W'(entry_index)),
        .wr_addr (address),
        .wr_name (name_offset),
        .rd_en   (rd_en),
        .rd_idx  (rd_idx),
        .rd_addr (rd_addr),
        .rd_name (rd_name)
    );

    sfl_scan #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_scan (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .action             (action),
        .address            (address),
        .symbol_count       (symbol_count_reg),
        .rd_en              (rd_en),
        .rd_idx             (rd_idx),
        .rd_addr            (rd_addr),
        .rd_name            (rd_name),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .found              (found),
        .symbol_address     (symbol_address),
        .symbol_name_offset (symbol_name_offset)
    );

endmodule

>>> tb/symbol_floor_lookup_top_test.sv
// ----------------------------------------------------------------------------
// symbol_floor_lookup_top_test
// Self-checking bench for the symbol table floor lookup.
// Loads table slots and queries addresses over the valid/stall channels.
// Each query's result is predicted from a shadow copy of the table and the
// symbol count, then checked against the block's output in arrival order.
// ----------------------------------------------------------------------------
module symbol_floor_lookup_top_test;

    import sfl_pkg::*;

    localparam int CYCLE_LIMIT = 10_000_000;
    localparam int MAX_REPORTS = 10;
    localparam logic [ADDR_W-1:0] CLUSTER_BASE = 64'hFFFF_8000_0010_0000;
    localparam logic [ADDR_W-1:0] ADDR_MAX = '1;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] start;
        logic [NAME_W-1:0] name;
    } floor_hit_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [COUNT_W-1:0] cfg_wr_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               action = ACTION_LOAD;
    logic [ENTRY_W-1:0] entry_index = '0;
    logic [ADDR_W-1:0]  address = '0;
    logic [NAME_W-1:0]  name_offset = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               found;
    logic [ADDR_W-1:0]  symbol_address;
    logic [NAME_W-1:0]  symbol_name_offset;

    // shadow of the symbol table and the active scan length
    logic [ADDR_W-1:0] sym_start [DEPTH_DEFAULT];
    logic [NAME_W-1:0] sym_name  [DEPTH_DEFAULT];
    int unsigned       scan_count = 0;

    floor_hit_t expected_hits [$];
    int         error_count = 0;
    int         result_count = 0;
    int         cycle_count = 0;
    int         send_gap_pct = 0;
    int         stall_pct = 0;

    symbol_floor_lookup_top dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .action             (action),
        .entry_index        (entry_index),
        .address            (address),
        .name_offset        (name_offset),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .found              (found),
        .symbol_address     (symbol_address),
        .symbol_name_offset (symbol_name_offset)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // greatest start address not above key; later slot wins on a tie
    function automatic floor_hit_t floor_lookup(input logic [ADDR_W-1:0] key);
        floor_hit_t hit;
        hit = '0;
        for (int i = 0; i < scan_count; i++)
        begin
            if (key >= sym_start[i] && sym_start[i] >= hit.start)
            begin
                hit.found = 1'b1;
                hit.start = sym_start[i];
                hit.name  = sym_name[i];
            end
        end
        return hit;
    endfunction

    function automatic logic [ADDR_W-1:0] random_symbol_start();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 10)
            return '0;
        if (pick < 20 && scan_count > 0)
            return sym_start[$urandom_range(scan_count - 1)];
        if (pick < 35)
            return $urandom_range(255);
        if (pick < 85)
            return CLUSTER_BASE + $urandom_range(16'hFFFF);
        return {$urandom, $urandom};
    endfunction

    function automatic logic [ADDR_W-1:0] random_lookup_address();
        int unsigned       pick;
        logic [ADDR_W-1:0] near;
        pick = $urandom_range(99);
        if (pick < 45 && scan_count > 0)
        begin
            near = sym_start[$urandom_range(scan_count - 1)];
            case ($urandom_range(3))
                0: return near - 1;
                1: return near;
                2: return near + 1;
                default: return near + $urandom_range(4095);
            endcase
        end
        if (pick < 75)
            return CLUSTER_BASE + $urandom_range(20'hFFFFF);
        if (pick < 85)
            return $urandom_range(300);
        if (pick < 90)
            return ADDR_MAX;
        return {$urandom, $urandom};
    endfunction

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    task automatic check_result();
        floor_hit_t want;
        result_count++;
        if (expected_hits.size() == 0)
        begin
            note_error($sformatf("ERROR: unexpected result %0d: found=%0b addr=%h name=%h",
                                 result_count, found, symbol_address, symbol_name_offset));
            return;
        end
        want = expected_hits.pop_front();
        if (found !== want.found || symbol_address !== want.start
            || symbol_name_offset !== want.name)
            note_error($sformatf({"ERROR: result %0d: expected found=%0b addr=%h name=%h,",
                                  " got found=%0b addr=%h name=%h"},
                                 result_count, want.found, want.start, want.name,
                                 found, symbol_address, symbol_name_offset));
    endtask

    // result side: sample at the edge, then decide the stall for the next cycle
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && !out_stall)
            check_result();
        out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end

    task automatic send_item(input logic act, input logic [ENTRY_W-1:0] slot,
                             input logic [ADDR_W-1:0] addr, input logic [NAME_W-1:0] name);
        while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        entry_index <= slot;
        address     <= addr;
        name_offset <= name;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        if (act == ACTION_LOAD)
        begin
            sym_start[slot] = addr;
            sym_name[slot]  = name;
        end
        else
            expected_hits.push_back(floor_lookup(addr));
    endtask

    // tail covers a load or scan still in flight after the last result
    task automatic wait_for_results(input bit with_tail);
        while (expected_hits.size() != 0)
            @(posedge clk);
        if (with_tail)
            repeat (scan_count + 8) @(posedge clk);
    endtask

    task automatic write_symbol_count(input logic [COUNT_W-1:0] value);
        in_valid <= 1'b0;
        wait_for_results(1'b1);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        scan_count = (value > DEPTH_DEFAULT) ? DEPTH_DEFAULT : value;
    endtask

    task automatic test_empty_table();
        send_item(ACTION_QUERY, '0, '0, '0);
        send_item(ACTION_QUERY, '1, ADDR_MAX, '1);
    endtask

    task automatic test_directed_floor();
        // two slots at the same address: the later one must win
        send_item(ACTION_LOAD, 10'd0, 64'h0000_0000_0000_1000, 32'hFFFF_FFFF);
        send_item(ACTION_LOAD, 10'd1, 64'h0000_0000_0000_1000, 32'h0000_0001);
        send_item(ACTION_LOAD, 10'd2, ADDR_MAX, 32'h0000_0000);
        send_item(ACTION_LOAD, 10'd3, 64'h8000_0000_0000_0000, 32'h0000_0055);
        send_item(ACTION_LOAD, 10'd4, 64'h0, 32'hAAAA_AAAA);
        send_item(ACTION_LOAD, 10'd5, 64'h10, 32'h5555_5555);

        write_symbol_count(11'd4);
        send_item(ACTION_QUERY, '0, 64'h0, '0);
        send_item(ACTION_QUERY, '0, 64'hFFF, '0);
        send_item(ACTION_QUERY, '0, 64'h1000, '0);
        send_item(ACTION_QUERY, '0, 64'h7FFF_FFFF_FFFF_FFFF, '0);
        send_item(ACTION_QUERY, '0, 64'h8000_0000_0000_0000, '0);
        send_item(ACTION_QUERY, '0, ADDR_MAX, '0);

        // symbol at address zero now in range
        write_symbol_count(11'd6);
        send_item(ACTION_QUERY, '0, 64'h0, '0);
        send_item(ACTION_QUERY, '0, 64'hF, '0);
        send_item(ACTION_QUERY, '0, 64'h10, '0);
        send_item(ACTION_QUERY, '0, ADDR_MAX - 1, '0);
    endtask

    task automatic test_full_table();
        stall_pct = 31;
        for (int slot = 0; slot < DEPTH_DEFAULT - 1; slot++)
            send_item(ACTION_LOAD, slot[ENTRY_W-1:0], random_symbol_start(), $urandom);
        send_item(ACTION_LOAD, 10'd1023, ADDR_MAX, 32'h0BAD_F00D);

        write_symbol_count(11'd1024);
        send_item(ACTION_QUERY, '0, ADDR_MAX, '0);
        send_item(ACTION_QUERY, '0, 64'h0, '0);
        send_item(ACTION_QUERY, '0, random_lookup_address(), '0);
        send_item(ACTION_QUERY, '0, random_lookup_address(), '0);

        // counts above the depth saturate
        write_symbol_count(11'd2047);
        send_item(ACTION_QUERY, '1, ADDR_MAX, '1);
        send_item(ACTION_QUERY, '0, random_lookup_address(), '0);
        send_item(ACTION_QUERY, '0, random_lookup_address(), '0);

        write_symbol_count(11'd1500);
        send_item(ACTION_QUERY, '0, random_lookup_address(), '0);
        send_item(ACTION_QUERY, '0, random_lookup_address(), '0);
    endtask

    task automatic test_random_traffic(input int gap_pct, input int stall_chance,
                                       input int n_items);
        int unsigned        pick;
        int unsigned        count_value;
        logic [ENTRY_W-1:0] slot;
        send_gap_pct = gap_pct;
        stall_pct    = stall_chance;
        for (int blk = 0; blk < 4; blk++)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                count_value = 0;
            else if (pick < 16)
                count_value = 1;
            else if (pick < 20)
                count_value = DEPTH_DEFAULT;
            else if (pick < 24)
                count_value = $urandom_range(2047, DEPTH_DEFAULT + 1);
            else
                count_value = $urandom_range(64, 2);
            write_symbol_count(count_value[COUNT_W-1:0]);

            for (int k = 0; k < n_items / 4; k++)
            begin
                // occasionally hold off until the result side is empty
                if ($urandom_range(99) < 2 && expected_hits.size() != 0)
                begin
                    in_valid <= 1'b0;
                    wait_for_results(1'b0);
                end
                if ($urandom_range(99) < 45)
                begin
                    if (scan_count > 0 && $urandom_range(99) < 70)
                        slot = $urandom_range(scan_count - 1);
                    else
                        slot = $urandom_range(DEPTH_DEFAULT - 1);
                    send_item(ACTION_LOAD, slot, random_symbol_start(), $urandom);
                end
                else
                    send_item(ACTION_QUERY, $urandom, random_lookup_address(), $urandom);
            end
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_directed_floor();
        test_full_table();
        test_random_traffic(0, 0, 145);
        test_random_traffic(54, 0, 145);
        test_random_traffic(0, 54, 145);
        test_random_traffic(31, 31, 145);

        in_valid <= 1'b0;
        wait_for_results(1'b1);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> sim.f
sv/sfl_pkg.sv
sv/sfl_table.sv
sv/sfl_scan.sv
sv/symbol_floor_lookup_top.sv
tb/symbol_floor_lookup_top_test.sv
